// File: hw/rtl/assert_macros.svh
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define LPMD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");

`define LPMD_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("forbidden condition seen");

`else

`define LPMD_ASSERT(lbl, clk, rstn, prop)

`define LPMD_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: hw/rtl/lpmd_pkg.sv
package lpmd_pkg;

	localparam int unsigned CHUNK_COUNT = 10000;
	localparam int unsigned CHUNK_BYTES = 1024;
	localparam logic [30:0] DEFAULT_MAX_SIZE = 31'(CHUNK_COUNT * CHUNK_BYTES);
	localparam logic [31:0] NAME_FLAG_MASK = 32'h4000_0000;
	localparam int unsigned HEADER_BYTES = 8;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_BODY  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_SIZE      = 2'd1;
	localparam logic [1:0] ERR_NAME_LEN  = 2'd2;
	localparam logic [1:0] ERR_BODY_LEN  = 2'd3;

	typedef struct packed {
		logic [1:0] error_code;
		logic       encrypted;
		logic       last_of_message;
		logic [1:0] kind;
		logic [7:0] out_byte;
	} result_t;

endpackage

// File: hw/rtl/lpmd_front.sv
`include "assert_macros.svh"

module lpmd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,    // data_byte
	input  logic [0:0]          s_tuser,    // new_connection
	input  logic [30:0]         max_size,
	input  logic                q_ready,
	output logic                push,
	output lpmd_pkg::result_t   push_data
);
	import lpmd_pkg::*;

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_NAME    = 2'd1;
	localparam logic [1:0] PH_BODY    = 2'd2;
	localparam logic [1:0] PH_DISCARD = 2'd3;

	localparam logic [2:0] LAST_HDR_IDX = 3'(HEADER_BYTES - 1);
	localparam logic [2:0] SIZE_DONE_IDX = 3'd4;

	logic [1:0]  phase_q, phase_d, ph;
	logic [2:0]  cnt_q, cnt_d, cnt;
	logic [29:0] name_rem_q, name_rem_d;
	logic [30:0] body_rem_q, body_rem_d;
	logic        flag_q, flag_d;
	logic [7:0]  hdr_q [7];
	logic [32:0] size_m8_q;

	logic        accept, nc;
	logic [31:0] size_word, name_word, name_size;
	logic [32:0] body_diff;
	logic        err_size, err_name, err_body;

	always_comb begin
		s_tready  = q_ready;
		accept    = s_tvalid & q_ready;
		nc        = s_tuser[0];
		ph        = nc ? PH_HEADER : phase_q;
		cnt       = nc ? 3'd0 : cnt_q;
		size_word = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
		name_word = {s_tdata, hdr_q[6], hdr_q[5], hdr_q[4]};
		name_size = name_word & ~NAME_FLAG_MASK;
		body_diff = size_m8_q - {1'b0, name_size};
		err_size  = size_word[31] || (size_word > {1'b0, max_size});
		err_name  = name_size[31] || (name_size > size_word);
		err_body  = body_diff[32];
	end

	always_comb begin
		phase_d    = ph;
		cnt_d      = cnt;
		name_rem_d = name_rem_q;
		body_rem_d = body_rem_q;
		flag_d     = flag_q;
		push       = 1'b0;
		push_data  = '0;
		unique case (ph)
			PH_HEADER: begin
				if (cnt != LAST_HDR_IDX) begin
					cnt_d = cnt + 3'd1;
				end else begin
					cnt_d = 3'd0;
					push_data.kind = KIND_ERROR;
					push_data.last_of_message = 1'b1;
					priority if (err_size) begin
						phase_d = PH_DISCARD;
						push = 1'b1;
						push_data.error_code = ERR_SIZE;
					end else if (err_name) begin
						phase_d = PH_DISCARD;
						push = 1'b1;
						push_data.error_code = ERR_NAME_LEN;
					end else if (err_body) begin
						phase_d = PH_DISCARD;
						push = 1'b1;
						push_data.error_code = ERR_BODY_LEN;
					end else begin
						flag_d     = name_word[30];
						name_rem_d = name_size[29:0];
						body_rem_d = body_diff[30:0];
						if (name_size == '0 && body_diff[30:0] == '0) begin
							phase_d = PH_HEADER;
							push = 1'b1;
							push_data.kind = KIND_EMPTY;
							push_data.encrypted = name_word[30];
						end else begin
							phase_d = (name_size != '0) ? PH_NAME : PH_BODY;
						end
					end
				end
			end
			PH_NAME: begin
				name_rem_d = name_rem_q - 30'd1;
				push = 1'b1;
				push_data.out_byte = s_tdata;
				push_data.kind = KIND_NAME;
				push_data.encrypted = flag_q;
				push_data.last_of_message = (name_rem_q == 30'd1) && (body_rem_q == '0);
				if (name_rem_q == 30'd1) begin
					phase_d = (body_rem_q != '0) ? PH_BODY : PH_HEADER;
				end
			end
			PH_BODY: begin
				body_rem_d = body_rem_q - 31'd1;
				push = 1'b1;
				push_data.out_byte = s_tdata;
				push_data.kind = KIND_BODY;
				push_data.encrypted = flag_q;
				push_data.last_of_message = (body_rem_q == 31'd1);
				if (body_rem_q == 31'd1) begin
					phase_d = PH_HEADER;
				end
			end
			PH_DISCARD: begin
			end
			default: begin
			end
		endcase
		push = push & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			cnt_q      <= 3'd0;
			name_rem_q <= '0;
			body_rem_q <= '0;
			flag_q     <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			name_rem_q <= name_rem_d;
			body_rem_q <= body_rem_d;
			flag_q     <= flag_d;
		end
	end

	// header byte capture and early size minus header
	always_ff @(posedge clk) begin
		if (accept && ph == PH_HEADER && cnt != LAST_HDR_IDX) begin
			hdr_q[cnt] <= s_tdata;
		end
		if (accept && ph == PH_HEADER && cnt == SIZE_DONE_IDX) begin
			size_m8_q <= {1'b0, size_word} - 33'(HEADER_BYTES);
		end
	end

	`LPMD_ASSERT(a_err_fields, clk, arst_n, (push && push_data.kind == KIND_ERROR) |-> (push_data.last_of_message && !push_data.encrypted && push_data.error_code != ERR_NONE))
	`LPMD_ASSERT(a_discard_holds, clk, arst_n, (accept && !nc && phase_q == PH_DISCARD) |=> (phase_q == PH_DISCARD))
	`LPMD_ASSERT(a_cnt_in_header, clk, arst_n, (cnt_q != 3'd0) |-> (phase_q == PH_HEADER))

endmodule

// File: hw/rtl/lpmd_queue.sv
`include "assert_macros.svh"

module lpmd_queue #(
	parameter int unsigned DEPTH = lpmd_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lpmd_pkg::result_t   push_data,
	output logic                push_ready,
	input  logic                pop,
	output logic                pop_valid,
	output lpmd_pkg::result_t   pop_data
);
	import lpmd_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	result_t       mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`LPMD_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && count_q == FULL_CNT)
	`LPMD_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && count_q == '0)
	`LPMD_ASSERT(a_count_track, clk, arst_n, (push && !pop) |=> (count_q == $past(count_q) + CW'(1)))

endmodule

// File: hw/rtl/lpmd_back.sv
module lpmd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  lpmd_pkg::result_t   q_data,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,    // out_byte
	output logic [4:0]          m_tuser,    // kind[1:0], encrypted, error_code[1:0]
	output logic                m_tlast     // last_of_message
);
	import lpmd_pkg::*;

	logic    out_valid_q;
	result_t out_q;

	assign q_pop    = q_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.out_byte;
	assign m_tuser  = {out_q.error_code, out_q.encrypted, out_q.kind};
	assign m_tlast  = out_q.last_of_message;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= q_data;
		end
	end

endmodule

// File: hw/rtl/length_prefixed_message_deframer_core.sv
// channel    dir  handshake          tdata        tuser                       tlast
// s_ (bytes) in   s_tvalid/s_tready  data_byte    new_connection              -
// m_ (out)   out  m_tvalid/m_tready  out_byte     kind, encrypted, error_code last_of_message
// cfg        in   cfg_wr_en          cfg_wr_data = max_message_size          -
//
// one input byte per cycle while the queue has room; each result passes the result queue, then the output register
// header checks settle in the cycle of the eighth header byte, in the front parser
// the result queue (QUEUE_DEPTH entries) and output register let each side stall alone
// s_tready drops only while the queue is full
// arst_n clears parser state, queue and output; max_message_size resets to 10240000
module length_prefixed_message_deframer_core #(
	parameter int unsigned QUEUE_DEPTH = lpmd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // data_byte
	input  logic [0:0]  s_tuser,    // new_connection
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // out_byte
	output logic [4:0]  m_tuser,    // kind[1:0], encrypted, error_code[1:0]
	output logic        m_tlast,    // last_of_message
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data // max_message_size
);
	import lpmd_pkg::*;

	logic [30:0] max_size_q;
	logic        q_ready, push, q_valid, q_pop;
	result_t     push_data, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= DEFAULT_MAX_SIZE;
		end else if (cfg_wr_en) begin
			max_size_q <= cfg_wr_data;
		end
	end

	lpmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.max_size  (max_size_q),
		.q_ready   (q_ready),
		.push      (push),
		.push_data (push_data)
	);

	lpmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_data   (q_data)
	);

	lpmd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
